/* design/fbs_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the free-run bitmap summary block.
package fbs_pkg;

  localparam int WORD_BITS_DEF         = 32;
  localparam int SUMMARY_LEVELS_DEF    = 32;
  localparam int MAX_BITMAP_BLOCKS_DEF = 64;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam int BBL_W      = 5;
  localparam int NB_W       = 7;
  localparam int LVL_W      = 5;
  localparam int RBLK_W     = 6;
  localparam int WIDX_W     = 27;
  localparam int DATA_W     = 32;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS_LOG2   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_BITMAP_BLOCKS = 1'd1;

  localparam logic [BBL_W-1:0] BBL_RESET = 5'd15;
  localparam logic [NB_W-1:0]  NB_RESET  = 7'd64;

  localparam logic OPR_EXTENT = 1'b0;
  localparam logic OPR_READ   = 1'b1;

  localparam logic KIND_WORD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [1:0] {
    MOP_NONE,
    MOP_INC,
    MOP_READ
  } mop_kind_t;

  typedef struct packed {
    logic              valid;
    logic              kind;
    logic [WIDX_W-1:0] word_index;
    logic [DATA_W-1:0] bitmap_word;
    logic [DATA_W-1:0] summary_count;
    logic [DATA_W-1:0] free_total;
    logic              is_final;
  } res_t;

  typedef struct packed {
    mop_kind_t         kind;
    logic [DATA_W-1:0] arg;
  } mop_t;

  function automatic logic [LVL_W-1:0] floor_log2(input logic [DATA_W-1:0] v);
    logic [LVL_W-1:0] r;
    r = '0;
    for (int i = 1; i < DATA_W; i++) begin
      if (v[i]) r = LVL_W'(i);
    end
    return r;
  endfunction

endpackage

/* design/fbs_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM with registered read.
module fbs_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = 11
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

/* design/fbs_front.sv */
`timescale 1ns / 1ps
// Extent packing, run tracking and first pipeline slot.
module fbs_front
  import fbs_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int DEPTH     = SUMMARY_LEVELS_DEF * MAX_BITMAP_BLOCKS_DEF,
  parameter int BLK_W     = 12
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [BBL_W-1:0]        block_bits_log2,
  input  logic                    hold,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    operation,
  input  logic                    extent_free,
  input  logic                    last_extent,
  input  logic [LVL_W-1:0]        read_level,
  input  logic [RBLK_W-1:0]       read_block,
  output logic                    s_valid,
  input  logic                    s_ready,
  output fbs_pkg::res_t           s_res,
  output fbs_pkg::mop_t           s_mop,
  output logic [BLK_W-1:0]        s_blk
);

  localparam int BP_W = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] accum;
  logic [BP_W-1:0]      bitpos;
  logic [DATA_W-1:0]    extent_number;
  logic [WIDX_W-1:0]    word_counter;
  logic                 in_run;
  logic [DATA_W-1:0]    run_start;
  logic [DATA_W-1:0]    free_counter;
  logic [BLK_W-1:0]     cur_block;
  logic [BLK_W-1:0]     run_block;

  logic                 acc;
  logic                 is_read;
  logic [DATA_W-1:0]    fc_next;
  logic [WORD_BITS-1:0] accum_with;
  logic [DATA_W-1:0]    en1;
  logic                 used_close;
  logic                 do_close;
  logic [DATA_W-1:0]    close_len;
  logic [BLK_W-1:0]     close_blk;
  logic                 emit;
  logic [DATA_W-1:0]    bmask;
  logic                 blk_adv;
  logic [BLK_W-1:0]     cur_block_inc;
  logic                 slot_valid;

  assign in_stall = hold || (s_valid && !s_ready);
  assign acc      = in_valid && !in_stall;
  assign is_read  = (operation == OPR_READ);

  always_comb begin
    for (int i = 0; i < DATA_W; i++) begin
      bmask[i] = (BBL_W'(i) < block_bits_log2);
    end
  end

  assign fc_next    = extent_free ? free_counter + DATA_W'(1) : free_counter;
  assign accum_with = extent_free ? (accum | (WORD_BITS'(1) << bitpos)) : accum;
  assign en1        = extent_number + DATA_W'(1);
  assign used_close = !extent_free && in_run;
  assign do_close   = used_close || (extent_free && last_extent);
  assign close_len  = used_close ? extent_number - run_start
                                 : en1 - (in_run ? run_start : extent_number);
  assign close_blk  = in_run ? run_block : cur_block;
  assign emit       = (bitpos == BP_W'(WORD_BITS - 1)) || last_extent;
  assign blk_adv    = ((en1 & bmask) == '0);
  assign cur_block_inc = (cur_block >= BLK_W'(DEPTH)) ? cur_block : cur_block + BLK_W'(1);
  assign slot_valid = is_read || emit || do_close;

  always_ff @(posedge clk) begin
    if (rst) begin
      accum         <= '0;
      bitpos        <= '0;
      extent_number <= '0;
      word_counter  <= '0;
      in_run        <= 1'b0;
      run_start     <= '0;
      free_counter  <= '0;
      cur_block     <= '0;
      run_block     <= '0;
    end else if (acc && !is_read) begin
      free_counter <= fc_next;
      if (emit) begin
        accum  <= '0;
        bitpos <= '0;
      end else begin
        accum  <= accum_with;
        bitpos <= bitpos + BP_W'(1);
      end
      if (last_extent) begin
        extent_number <= '0;
        word_counter  <= '0;
        cur_block     <= '0;
        in_run        <= 1'b0;
        run_start     <= '0;
        run_block     <= '0;
      end else begin
        extent_number <= en1;
        in_run        <= extent_free;
        if (extent_free && !in_run) begin
          run_start <= extent_number;
          run_block <= cur_block;
        end
        if (emit) begin
          word_counter <= word_counter + WIDX_W'(1);
          if (blk_adv) cur_block <= cur_block_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else begin
      if (acc) s_valid <= slot_valid;
      else if (s_ready) s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && slot_valid) begin
      s_res.summary_count <= '0;
      if (is_read) begin
        s_res.valid       <= 1'b1;
        s_res.kind        <= KIND_READ;
        s_res.word_index  <= '0;
        s_res.bitmap_word <= '0;
        s_res.free_total  <= free_counter;
        s_res.is_final    <= 1'b0;
        s_mop.kind        <= MOP_READ;
        s_mop.arg         <= DATA_W'(read_level);
        s_blk             <= BLK_W'(read_block);
      end else begin
        s_res.valid       <= emit;
        s_res.kind        <= KIND_WORD;
        s_res.word_index  <= word_counter;
        s_res.bitmap_word <= DATA_W'(accum_with);
        s_res.free_total  <= fc_next;
        s_res.is_final    <= last_extent;
        s_mop.kind        <= do_close ? MOP_INC : MOP_NONE;
        s_mop.arg         <= close_len;
        s_blk             <= close_blk;
      end
    end
  end

endmodule

/* design/fbs_summ.sv */
`timescale 1ns / 1ps
// Summary store pipeline: offset, read-modify-write with forwarding, clear, output register.
module fbs_summ
  import fbs_pkg::*;
#(
  parameter int DEPTH  = SUMMARY_LEVELS_DEF * MAX_BITMAP_BLOCKS_DEF,
  parameter int ADDR_W = 11,
  parameter int BLK_W  = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [NB_W-1:0]    num_bitmap_blocks,
  output logic               clearing,
  input  logic               s_valid,
  output logic               s_ready,
  input  fbs_pkg::res_t      s_res,
  input  fbs_pkg::mop_t      s_mop,
  input  logic [BLK_W-1:0]   s_blk,
  output logic               out_valid,
  input  logic               out_stall,
  output fbs_pkg::res_t      out_res
);

  localparam int OFF_W = ((LVL_W + NB_W > BLK_W) ? LVL_W + NB_W : BLK_W) + 1;

  logic              v2;
  res_t              res2;
  mop_t              mop2;
  logic [BLK_W-1:0]  blk2;

  logic              v3;
  res_t              res3;
  mop_kind_t         kind3;
  logic              inr3;
  logic [ADDR_W-1:0] addr3;
  logic              fwd_hit;
  logic [DATA_W-1:0] fwd_data;

  logic              clr_addr_last;
  logic [ADDR_W-1:0] clr_addr;

  logic              ready_out;
  logic              ready3;
  logic              ren;
  logic [LVL_W-1:0]  lvl2;
  logic [OFF_W-1:0]  off2;
  logic              inr2;
  logic [ADDR_W-1:0] addr2;
  logic [DATA_W-1:0] rdata;
  logic [DATA_W-1:0] data3;
  logic [DATA_W-1:0] upd3;
  logic              we3;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  res_t              res3_out;

  assign ready_out = !out_valid || !out_stall;
  assign ready3    = !v3 || ready_out;
  assign s_ready   = !v2 || ready3;
  assign ren       = v2 && ready3;

  assign lvl2  = (mop2.kind == MOP_INC) ? floor_log2(mop2.arg) : mop2.arg[LVL_W-1:0];
  assign off2  = OFF_W'(lvl2) * OFF_W'(num_bitmap_blocks) + OFF_W'(blk2);
  assign inr2  = (off2 < OFF_W'(DEPTH));
  assign addr2 = off2[ADDR_W-1:0];

  assign data3 = fwd_hit ? fwd_data : rdata;
  assign upd3  = data3 + DATA_W'(1);
  assign we3   = v3 && ready_out && (kind3 == MOP_INC) && inr3;

  assign clr_addr_last = (clr_addr == ADDR_W'(DEPTH - 1));
  assign ram_we    = clearing || we3;
  assign ram_waddr = clearing ? clr_addr : addr3;
  assign ram_wdata = clearing ? '0 : upd3;

  fbs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ren),
    .raddr(addr2),
    .rdata(rdata)
  );

  always_comb begin
    res3_out = res3;
    res3_out.summary_count = ((kind3 == MOP_READ) && inr3) ? data3 : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr_last) clearing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_ready) v2 <= s_valid;
      if (ready3) v3 <= v2;
      if (ready_out) out_valid <= v3 && res3.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      res2 <= s_res;
      mop2 <= s_mop;
      blk2 <= s_blk;
    end
    if (ren) begin
      res3     <= res2;
      kind3    <= ((mop2.kind == MOP_INC) && (mop2.arg == '0)) ? MOP_NONE : mop2.kind;
      inr3     <= inr2;
      addr3    <= addr2;
      fwd_hit  <= we3 && (addr3 == addr2);
      fwd_data <= upd3;
    end
    if (ready_out && v3) out_res <= res3_out;
  end

endmodule

/* design/free_run_bitmap_summary.sv */
`timescale 1ns / 1ps
// Top level of the free-run bitmap summary block.
//
//   channel  direction  handshake            payload
//   cfg      in         cfg_wr_en            cfg_index, cfg_data
//   in       in         in_valid / in_stall  operation, extent_free, last_extent,
//                                            read_level, read_block
//   out      out        out_valid / out_stall result_kind, word_index, bitmap_word,
//                                            summary_count, free_total, is_final
//
// One item per cycle while in_stall is low; a result passes from the front slot through
// the v2 and v3 stages of the summary RAM read-modify-write pipeline to the output register.
// After reset the summary store is cleared, one entry per cycle, with in_stall high until
// all SUMMARY_LEVELS * MAX_BITMAP_BLOCKS entries (2048 by default) are cleared.
// out_stall backs up through the pipeline slots to in_stall.
module free_run_bitmap_summary
  import fbs_pkg::*;
#(
  parameter int WORD_BITS         = WORD_BITS_DEF,
  parameter int SUMMARY_LEVELS    = SUMMARY_LEVELS_DEF,
  parameter int MAX_BITMAP_BLOCKS = MAX_BITMAP_BLOCKS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [fbs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fbs_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             operation,
  input  logic                             extent_free,
  input  logic                             last_extent,
  input  logic [fbs_pkg::LVL_W-1:0]        read_level,
  input  logic [fbs_pkg::RBLK_W-1:0]       read_block,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             result_kind,
  output logic [fbs_pkg::WIDX_W-1:0]       word_index,
  output logic [fbs_pkg::DATA_W-1:0]       bitmap_word,
  output logic [fbs_pkg::DATA_W-1:0]       summary_count,
  output logic [fbs_pkg::DATA_W-1:0]       free_total,
  output logic                             is_final
);

  localparam int DEPTH  = SUMMARY_LEVELS * MAX_BITMAP_BLOCKS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BLK_W  = (ADDR_W + 1 > RBLK_W) ? ADDR_W + 1 : RBLK_W;

  logic [BBL_W-1:0] block_bits_log2;
  logic [NB_W-1:0]  num_bitmap_blocks;

  logic             clearing;
  logic             s_valid;
  logic             s_ready;
  res_t             s_res;
  mop_t             s_mop;
  logic [BLK_W-1:0] s_blk;
  res_t             out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_bits_log2   <= BBL_RESET;
      num_bitmap_blocks <= NB_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_BLOCK_BITS_LOG2:   block_bits_log2   <= cfg_data[BBL_W-1:0];
        REG_NUM_BITMAP_BLOCKS: num_bitmap_blocks <= cfg_data[NB_W-1:0];
      endcase
    end
  end

  fbs_front #(
    .WORD_BITS(WORD_BITS),
    .DEPTH    (DEPTH),
    .BLK_W    (BLK_W)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .block_bits_log2(block_bits_log2),
    .hold           (clearing),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .extent_free    (extent_free),
    .last_extent    (last_extent),
    .read_level     (read_level),
    .read_block     (read_block),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_res          (s_res),
    .s_mop          (s_mop),
    .s_blk          (s_blk)
  );

  fbs_summ #(
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W),
    .BLK_W (BLK_W)
  ) u_summ (
    .clk              (clk),
    .rst              (rst),
    .num_bitmap_blocks(num_bitmap_blocks),
    .clearing         (clearing),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .s_res            (s_res),
    .s_mop            (s_mop),
    .s_blk            (s_blk),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_res          (out_res)
  );

  assign result_kind   = out_res.kind;
  assign word_index    = out_res.word_index;
  assign bitmap_word   = out_res.bitmap_word;
  assign summary_count = out_res.summary_count;
  assign free_total    = out_res.free_total;
  assign is_final      = out_res.is_final;

endmodule
